>>> src/civil_datetime_to_epoch_ms_assert.svh
// Assertion macros shared by the checker of the date to epoch converter.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef CIVIL_DATETIME_TO_EPOCH_MS_ASSERT_SVH
`define CIVIL_DATETIME_TO_EPOCH_MS_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define CDTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define CDTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cdte_pkg.sv
// Types, constants and lookup functions of the date to epoch converter.
// Used by cdte_days and civil_datetime_to_epoch_ms; depends on nothing.
package cdte_pkg;

  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinW    = 6;
  localparam int SecW    = 6;
  localparam int MsW     = 10;
  localparam int InDataW = 56;
  localparam int EpochW  = 49;
  localparam int OutDataW = 56;

  localparam int DayNumW = 23;
  localparam int SodW    = 17;
  localparam int SodMsW  = 27;
  localparam int OffDayW = 9;
  localparam int QuotW   = 8;

  localparam int YearMax     = 9999;
  localparam int MonthMax    = 12;
  localparam int MonthFeb    = 2;
  localparam int MonthMar    = 3;
  localparam int LeapDay     = 29;
  localparam int Recip100    = 5243;
  localparam int RecipShift  = 19;
  localparam int Days4Years  = 1461;
  localparam int MarchShift  = 306;
  localparam int EpochDay    = 719163;
  localparam int SecPerHour  = 3600;
  localparam int SecPerMin   = 60;
  localparam int MsPerSec    = 1000;
  localparam int Century     = 100;
  localparam logic signed [27:0] MsPerDay = 28'sd86400000;

  typedef struct packed {
    logic [MsW-1:0]    millisecond;
    logic [SecW-1:0]   second;
    logic [MinW-1:0]   minute;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } cdte_in_t;

  typedef struct packed {
    logic                      ok;
    logic signed [DayNumW-1:0] days;
    logic [SodMsW-1:0]         sodms;
  } cdte_days_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
      4'd2:                                        r = 5'd28;
      default:                                     r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [OffDayW-1:0] march_offset(input logic [MonthW-1:0] m);
    logic [OffDayW-1:0] r;
    unique case (m)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/cdte_days.sv
// First three pipeline stages: date checks, day number and time of day.
// Depends on cdte_pkg; stage enables come from civil_datetime_to_epoch_ms.
module cdte_days (
  input  logic                  clk_i,
  input  logic [2:0]            en_i,
  input  cdte_pkg::cdte_in_t    item_i,
  output cdte_pkg::cdte_days_t  res_o
);
  import cdte_pkg::*;

  logic [YearW-1:0]   year1_q, y1_q;
  logic [OffDayW-1:0] offday1_q;
  logic [SodW-1:0]    sod1_q;
  logic [MsW-1:0]     ms1_q;
  logic               range1_q, daygt1_q, feb29_1_q;

  logic [YearW-1:0]   y1_d;
  logic [OffDayW-1:0] offday1_d;
  logic [SodW-1:0]    sod1_d;
  logic               range1_d, daygt1_d, feb29_1_d;

  always_comb begin
    range1_d = (item_i.year != '0) && (item_i.year <= YearW'(YearMax)) &&
               (item_i.month != '0) && (item_i.month <= MonthW'(MonthMax));
    daygt1_d = item_i.day > month_len(item_i.month);
    feb29_1_d = (item_i.month == MonthW'(MonthFeb)) && (item_i.day == DayW'(LeapDay));
    y1_d = (item_i.month < MonthW'(MonthMar)) ? item_i.year - YearW'(1) : item_i.year;
    offday1_d = march_offset(item_i.month) + OffDayW'(item_i.day);
    sod1_d = SodW'(item_i.hour) * SodW'(SecPerHour) +
             SodW'(item_i.minute) * SodW'(SecPerMin) + SodW'(item_i.second);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      year1_q   <= item_i.year;
      y1_q      <= y1_d;
      offday1_q <= offday1_d;
      sod1_q    <= sod1_d;
      ms1_q     <= item_i.millisecond;
      range1_q  <= range1_d;
      daygt1_q  <= daygt1_d;
      feb29_1_q <= feb29_1_d;
    end
  end

  // Division by 100 is a multiply by a scaled reciprocal, exact for 14-bit values.
  logic [YearW+12:0]  qy_full, qyear_full;
  logic [YearW+10:0]  quad_full;
  logic [SodMsW-1:0]  sodms2_d;

  assign qy_full    = (YearW+13)'(y1_q) * (YearW+13)'(Recip100);
  assign qyear_full = (YearW+13)'(year1_q) * (YearW+13)'(Recip100);
  assign quad_full  = (YearW+11)'(y1_q) * (YearW+11)'(Days4Years);
  assign sodms2_d   = SodMsW'(sod1_q) * SodMsW'(MsPerSec) + SodMsW'(ms1_q);

  logic [QuotW-1:0]   qy2_q, qyear2_q;
  logic [DayNumW-1:0] quad2_q;
  logic [YearW-1:0]   year2_q;
  logic [OffDayW-1:0] offday2_q;
  logic [SodMsW-1:0]  sodms2_q;
  logic               range2_q, daygt2_q, feb29_2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      qy2_q     <= qy_full[RecipShift +: QuotW];
      qyear2_q  <= qyear_full[RecipShift +: QuotW];
      quad2_q   <= quad_full[YearW+10:2];
      year2_q   <= year1_q;
      offday2_q <= offday1_q;
      sodms2_q  <= sodms2_d;
      range2_q  <= range1_q;
      daygt2_q  <= daygt1_q;
      feb29_2_q <= feb29_1_q;
    end
  end

  logic [YearW:0]     cent;
  logic               leap;
  logic [DayNumW:0]   days_sum;
  cdte_days_t         res_d, res_q;

  always_comb begin
    cent = (YearW+1)'(qyear2_q) * (YearW+1)'(Century);
    leap = (year2_q[1:0] == 2'b00) &&
           (({1'b0, year2_q} != cent) || (qyear2_q[1:0] == 2'b00));
    days_sum = (DayNumW+1)'(quad2_q) - (DayNumW+1)'(qy2_q) +
               (DayNumW+1)'(qy2_q[QuotW-1:2]) + (DayNumW+1)'(offday2_q) -
               (DayNumW+1)'(MarchShift + EpochDay);
    res_d.ok    = range2_q && (!daygt2_q || (feb29_2_q && leap));
    res_d.days  = signed'(days_sum[DayNumW-1:0]);
    res_d.sodms = sodms2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> src/civil_datetime_to_epoch_ms.sv
// Top level of the Gregorian date and time to Unix milliseconds converter.
// Depends on cdte_pkg and cdte_days; five-stage pipeline with stream ports.
//
// The slave channel takes one date and time per word; the master channel
// returns one word per input word, in order. The result word carries the
// signed millisecond count since 1970-01-01 00:00:00 UTC in tdata and a
// date-valid flag in tuser. A rejected date (year or month out of range, or
// a day past the end of its month) gives all ones in the count and a zero
// flag.
// One word can be accepted every cycle while the receiver does not stall.
// The five register stages are the date decode, the reciprocal and year
// multiplies, the day-number sum, the multiply by the day length, and the
// final add.
// Reset clears all stage valid bits, so the pipeline comes up empty and
// ready. When the receiver stalls, the result word holds; stages behind it
// keep advancing until they fill any empty slots, and only then does
// s_axis_tready fall.
module civil_datetime_to_epoch_ms (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
  // second[39:34], millisecond[49:40], zero[55:50]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // epoch_ms[48:0], zero[55:49]
  output logic [55:0] m_axis_tdata,
  // date_valid[0]
  output logic        m_axis_tuser
);
  import cdte_pkg::*;

  localparam int Stages = 5;

  logic [Stages-1:0] valid_q, valid_d, en;

  always_comb begin
    en[Stages-1] = !valid_q[Stages-1] || m_axis_tready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[0] = en[0] ? s_axis_tvalid : valid_q[0];
    for (int k = 1; k < Stages; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  cdte_in_t   item;
  cdte_days_t days_res;

  assign item = cdte_in_t'(s_axis_tdata[$bits(cdte_in_t)-1:0]);

  cdte_days u_days (
    .clk_i (clk_i),
    .en_i  (en[2:0]),
    .item_i(item),
    .res_o (days_res)
  );

  logic signed [EpochW:0] prod_full;
  logic [EpochW-1:0]      prod4_q;
  logic [SodMsW-1:0]      sodms4_q;
  logic                   ok4_q;

  assign prod_full = days_res.days * MsPerDay;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      prod4_q  <= prod_full[EpochW-1:0];
      sodms4_q <= days_res.sodms;
      ok4_q    <= days_res.ok;
    end
  end

  logic [EpochW-1:0] epoch_d, epoch_q;
  logic              dvalid_q;

  assign epoch_d = ok4_q ? prod4_q + EpochW'(sodms4_q) : '1;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      epoch_q  <= epoch_d;
      dvalid_q <= ok4_q;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[Stages-1];
  assign m_axis_tdata  = {(OutDataW-EpochW)'(0), epoch_q};
  assign m_axis_tuser  = dvalid_q;

endmodule

>>> src/cdte_checker.sv
// Port-level checks of the date to epoch converter, bound to its top level.
// Depends on civil_datetime_to_epoch_ms_assert.svh for the assertion macros.
`include "civil_datetime_to_epoch_ms_assert.svh"

module cdte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [55:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `CDTE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")
  `CDTE_ASSERT_NOW(a_reject_ones, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[48:0] == 49'h1FFFFFFFFFFFF, "rejected date without all-ones count")
  `CDTE_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[55:49] == 7'd0, "padding bits of result word not zero")
  `CDTE_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready, "input not ready while output is empty")

endmodule

bind civil_datetime_to_epoch_ms cdte_checker u_cdte_checker (.*);
